### hdl/iprr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the record-route extractor
// no dependencies

package iprr_pkg;

    localparam int MAX_ROUTES  = 9;
    localparam int MAX_AREA    = 40;
    localparam int QUEUE_DEPTH = 4;

    localparam int AREA_W   = 6;
    localparam int ADDR_W   = 32;
    localparam int IDX_W    = 4;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_RR  = 8'd7;
    localparam logic [7:0] RR_MIN_OFFSET = 8'd4;

    // results of one accepted word, handed from parser to output stage
    typedef struct packed {
        logic              has_addr;
        logic              has_sum;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] wan;
        logic [IDX_W-1:0]  cnt;
        logic              ovf;
    } entry_t;

endpackage

### hdl/iprr_front.sv
`timescale 1ns / 1ps
// option parser: takes one options byte per word and produces the results it causes
// depends on iprr_pkg

module iprr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic [7:0]                      opt_byte,
    input  logic                            first,
    input  logic [iprr_pkg::AREA_W-1:0]     area_length,
    input  logic                            byte_valid,
    output logic                            push,
    output iprr_pkg::entry_t                entry
);

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_PTR,
        PH_SKIP,
        PH_STOP
    } phase_t;

    localparam logic [iprr_pkg::AREA_W-1:0] AREA_MAX = iprr_pkg::AREA_W'(iprr_pkg::MAX_AREA);
    localparam logic [iprr_pkg::IDX_W-1:0]  ROUTE_MAX = iprr_pkg::IDX_W'(iprr_pkg::MAX_ROUTES);

    logic [iprr_pkg::AREA_W-1:0]  bytes_left_reg, bytes_left_next;
    phase_t                       phase_reg, phase_next;
    logic                         kind_rr_reg, kind_rr_next;
    logic [iprr_pkg::AREA_W-1:0]  opt_len_reg, opt_len_next;
    logic [iprr_pkg::AREA_W-1:0]  skip_left_reg, skip_left_next;
    logic [iprr_pkg::AREA_W-1:0]  cap_left_reg, cap_left_next;
    logic [iprr_pkg::ADDR_W-1:0]  shift_reg, shift_next;
    logic [1:0]                   byte_pos_reg, byte_pos_next;
    logic [iprr_pkg::IDX_W-1:0]   routes_reg, routes_next;
    logic                         ovf_reg, ovf_next;
    logic [iprr_pkg::ADDR_W-1:0]  wan_reg, wan_next;

    always_comb begin
        logic [7:0]                  ptr;
        logic [7:0]                  room;
        logic                        has_addr;
        logic                        has_sum;
        logic [iprr_pkg::ADDR_W-1:0] addr_out;
        logic [iprr_pkg::IDX_W-1:0]  idx_out;

        bytes_left_next = bytes_left_reg;
        phase_next      = phase_reg;
        kind_rr_next    = kind_rr_reg;
        opt_len_next    = opt_len_reg;
        skip_left_next  = skip_left_reg;
        cap_left_next   = cap_left_reg;
        shift_next      = shift_reg;
        byte_pos_next   = byte_pos_reg;
        routes_next     = routes_reg;
        ovf_next        = ovf_reg;
        wan_next        = wan_reg;
        ptr             = 8'd0;
        room            = 8'd0;
        has_addr        = 1'b0;
        has_sum         = 1'b0;
        addr_out        = '0;
        idx_out         = '0;

        // packet start clears per-packet state, entry 1 stays
        if (first) begin
            bytes_left_next = (area_length > AREA_MAX) ? AREA_MAX : area_length;
            phase_next      = PH_KIND;
            kind_rr_next    = 1'b0;
            opt_len_next    = '0;
            skip_left_next  = '0;
            cap_left_next   = '0;
            shift_next      = '0;
            byte_pos_next   = '0;
            routes_next     = '0;
            ovf_next        = 1'b0;
        end

        if (first && bytes_left_next == '0) begin
            has_sum = 1'b1;
        end else if (byte_valid && bytes_left_next != '0) begin
            // address capture runs ahead of parsing
            if (cap_left_next != '0) begin
                cap_left_next = cap_left_next - 1'b1;
                shift_next    = {shift_next[iprr_pkg::ADDR_W-9:0], opt_byte};
                if (byte_pos_next == 2'd3) begin
                    byte_pos_next = '0;
                    if (routes_next < ROUTE_MAX) begin
                        has_addr = 1'b1;
                        addr_out = shift_next;
                        idx_out  = routes_next;
                        if (routes_next == iprr_pkg::IDX_W'(1)) begin
                            wan_next = shift_next;
                        end
                        routes_next = routes_next + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    shift_next = '0;
                end else begin
                    byte_pos_next = byte_pos_next + 1'b1;
                end
            end

            unique case (phase_next)
                PH_KIND: begin
                    if (opt_byte == iprr_pkg::OPT_EOL) begin
                        phase_next = PH_STOP;
                    end else if (opt_byte != iprr_pkg::OPT_NOP) begin
                        kind_rr_next = (opt_byte == iprr_pkg::OPT_RR);
                        phase_next   = PH_LEN;
                    end
                end
                PH_LEN: begin
                    room = {2'b00, bytes_left_next} + 8'd1;
                    if (opt_byte < 8'd2 || opt_byte > room) begin
                        phase_next = PH_STOP;
                    end else begin
                        opt_len_next = opt_byte[iprr_pkg::AREA_W-1:0];
                        if (opt_byte == 8'd2) begin
                            phase_next = PH_KIND;
                        end else if (kind_rr_next) begin
                            phase_next = PH_PTR;
                        end else begin
                            skip_left_next = opt_byte[iprr_pkg::AREA_W-1:0] - 6'd2;
                            phase_next     = PH_SKIP;
                        end
                    end
                end
                PH_PTR: begin
                    ptr = (opt_byte < {2'b00, opt_len_next}) ? opt_byte : {2'b00, opt_len_next};
                    if (ptr > iprr_pkg::RR_MIN_OFFSET) begin
                        ptr           = ptr - iprr_pkg::RR_MIN_OFFSET + 8'd3;
                        cap_left_next = {ptr[iprr_pkg::AREA_W-1:2], 2'b00};
                        byte_pos_next = '0;
                        shift_next    = '0;
                    end
                    skip_left_next = opt_len_next - 6'd3;
                    phase_next     = (skip_left_next != '0) ? PH_SKIP : PH_KIND;
                end
                PH_SKIP: begin
                    if (skip_left_next != '0) begin
                        skip_left_next = skip_left_next - 1'b1;
                    end
                    if (skip_left_next == '0) begin
                        phase_next = PH_KIND;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase

            bytes_left_next = bytes_left_next - 1'b1;
            if (bytes_left_next == '0) begin
                cap_left_next = '0;
                byte_pos_next = '0;
                shift_next    = '0;
                has_sum       = 1'b1;
            end
        end

        push           = in_accept && (has_addr || has_sum);
        entry.has_addr = has_addr;
        entry.has_sum  = has_sum;
        entry.addr     = addr_out;
        entry.idx      = idx_out;
        entry.wan      = wan_next;
        entry.cnt      = routes_next;
        entry.ovf      = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            phase_reg      <= PH_KIND;
            kind_rr_reg    <= 1'b0;
            opt_len_reg    <= '0;
            skip_left_reg  <= '0;
            cap_left_reg   <= '0;
            shift_reg      <= '0;
            byte_pos_reg   <= '0;
            routes_reg     <= '0;
            ovf_reg        <= 1'b0;
            wan_reg        <= '0;
        end else if (in_accept) begin
            bytes_left_reg <= bytes_left_next;
            phase_reg      <= phase_next;
            kind_rr_reg    <= kind_rr_next;
            opt_len_reg    <= opt_len_next;
            skip_left_reg  <= skip_left_next;
            cap_left_reg   <= cap_left_next;
            shift_reg      <= shift_next;
            byte_pos_reg   <= byte_pos_next;
            routes_reg     <= routes_next;
            ovf_reg        <= ovf_next;
            wan_reg        <= wan_next;
        end
    end

endmodule

### hdl/iprr_queue.sv
`timescale 1ns / 1ps
// short fifo of result entries between parser and output stage
// depends on iprr_pkg

module iprr_queue #(
    parameter int DEPTH = iprr_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  iprr_pkg::entry_t wr_entry,
    input  logic             pop,
    output iprr_pkg::entry_t rd_entry,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    iprr_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/iprr_back.sv
`timescale 1ns / 1ps
// output stage: turns queue entries into result words, address before summary
// depends on iprr_pkg

module iprr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  iprr_pkg::entry_t                rd_entry,
    input  logic                            empty,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [iprr_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int PAD_W = iprr_pkg::M_DATA_W - iprr_pkg::ADDR_W - 2 * iprr_pkg::IDX_W - 1;

    logic                           valid_reg, valid_next;
    logic [iprr_pkg::M_DATA_W-1:0]  data_reg, data_next;
    logic                           last_reg, last_next;
    logic                           pend_reg, pend_next;
    logic [iprr_pkg::ADDR_W-1:0]    sum_wan_reg, sum_wan_next;
    logic [iprr_pkg::IDX_W-1:0]     sum_cnt_reg, sum_cnt_next;
    logic                           sum_ovf_reg, sum_ovf_next;
    logic                           out_free;

    assign out_free = !valid_reg || m_axis_tready;
    assign pop      = out_free && !pend_reg && !empty;

    always_comb begin
        valid_next   = valid_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        pend_next    = pend_reg;
        sum_wan_next = sum_wan_reg;
        sum_cnt_next = sum_cnt_reg;
        sum_ovf_next = sum_ovf_reg;
        if (out_free) begin
            priority if (pend_reg) begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                data_next  = {PAD_W'(0), sum_ovf_reg, sum_cnt_reg,
                              iprr_pkg::IDX_W'(0), sum_wan_reg};
                pend_next  = 1'b0;
            end else if (!empty) begin
                valid_next   = 1'b1;
                sum_wan_next = rd_entry.wan;
                sum_cnt_next = rd_entry.cnt;
                sum_ovf_next = rd_entry.ovf;
                if (rd_entry.has_addr) begin
                    last_next = 1'b0;
                    data_next = {PAD_W'(0), rd_entry.ovf, rd_entry.cnt,
                                 rd_entry.idx, rd_entry.addr};
                    pend_next = rd_entry.has_sum;
                end else begin
                    last_next = 1'b1;
                    data_next = {PAD_W'(0), rd_entry.ovf, rd_entry.cnt,
                                 iprr_pkg::IDX_W'(0), rd_entry.wan};
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
        data_reg    <= data_next;
        last_reg    <= last_next;
        sum_wan_reg <= sum_wan_next;
        sum_cnt_reg <= sum_cnt_next;
        sum_ovf_reg <= sum_ovf_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

### hdl/ip_record_route_extractor.sv
`timescale 1ns / 1ps
// Record-route extractor for the IPv4 options area.
// Input stream: one options byte per word. A word with tuser[0] (first) set starts a
// packet and carries the area length; tuser[1] (byte_valid) says the byte is part of
// the area. A zero length gives only the summary word.
// Output stream: one word per captured address (tlast low) and one summary word at
// the end of the area (tlast high) with the route count and the kept entry 1.
// Throughput: one input word per cycle while s_axis_tready is high; the parser finishes each word in the cycle
// it is accepted. A word causes at most two output words, which leave one per cycle while m_axis_tready is high.
// An entry passes through the queue and then the output register before its output word appears.
// A four-entry queue sits between the parser and the output register; s_axis_tready
// drops only while that queue is full, so a stalled receiver backs up into the
// queue first and then into the input.
// Reset: synchronous, aresetn low clears parse state, the kept entry, the queue and
// the output valid. Addresses beyond the route table are dropped and flagged.
// Depends on iprr_pkg, iprr_front, iprr_queue, iprr_back.

module ip_record_route_extractor #(
    parameter int QUEUE_DEPTH = iprr_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [iprr_pkg::S_DATA_W-1:0]   s_axis_tdata,   // opt_byte, area_length
    input  logic [iprr_pkg::S_USER_W-1:0]   s_axis_tuser,   // first, byte_valid
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [iprr_pkg::M_DATA_W-1:0]   m_axis_tdata,   // address, route_index, route_count, overflow
    output logic                            m_axis_tlast    // is_summary
);

    logic             in_accept;
    logic             push;
    logic             pop;
    logic             empty;
    logic             full;
    iprr_pkg::entry_t wr_entry;
    iprr_pkg::entry_t rd_entry;

    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    iprr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .opt_byte    (s_axis_tdata[7:0]),
        .first       (s_axis_tuser[0]),
        .area_length (s_axis_tdata[8 +: iprr_pkg::AREA_W]),
        .byte_valid  (s_axis_tuser[1]),
        .push        (push),
        .entry       (wr_entry)
    );

    iprr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .empty    (empty),
        .full     (full)
    );

    iprr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_entry      (rd_entry),
        .empty         (empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### hdl/iprr_checker.sv
`timescale 1ns / 1ps
// port checks for the record-route extractor, bound to the top level
// depends on iprr_pkg and ip_record_route_extractor

module iprr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [iprr_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast
);

    localparam logic [iprr_pkg::IDX_W-1:0] ROUTE_MAX = iprr_pkg::IDX_W'(iprr_pkg::MAX_ROUTES);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // summary word carries index zero
    a_sum_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[35:32] == 4'd0)
        else $error("summary word with nonzero index");

    // address word count is its index plus one
    a_addr_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[39:36] == m_axis_tdata[35:32] + 4'd1)
        else $error("address word count does not follow index");

    // count never exceeds the table
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:36] <= ROUTE_MAX)
        else $error("route count beyond table size");

    // no output word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ip_record_route_extractor iprr_checker u_iprr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
